// ===== rtl/mf3_pkg.sv =====
package mf3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W       = 8;
    localparam int OUT_W       = 11;
    localparam int CFG_W       = 12;
    localparam int M_TDATA_W   = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WCMP_W      = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int HCMP_W      = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;
    localparam int MIN_DIM     = 5;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W:0]    wdim_t;
    typedef logic [ROW_W:0]    hdim_t;
    typedef logic [OUT_W-1:0]  coord_t;
    typedef logic [CFG_W-1:0]  cfg_data_t;
    typedef logic [WCMP_W-1:0] wcmp_t;
    typedef logic [HCMP_W-1:0] hcmp_t;

    // row-major 3x3 window, entry 4 is the centre
    typedef logic [8:0][PIX_W-1:0] pix_win_t;

    typedef struct packed {
        logic   emit;
        logic   inner;
        coord_t row;
        coord_t col;
    } win_ctrl_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    function automatic wdim_t clamp_width(cfg_data_t v);
        wcmp_t ve;
        ve = wcmp_t'(v);
        if (ve < wcmp_t'(MIN_DIM))
            return wdim_t'(MIN_DIM);
        else if (ve > wcmp_t'(MAX_WIDTH))
            return wdim_t'(MAX_WIDTH);
        else
            return wdim_t'(ve);
    endfunction

    function automatic hdim_t clamp_height(cfg_data_t v);
        hcmp_t ve;
        ve = hcmp_t'(v);
        if (ve < hcmp_t'(MIN_DIM))
            return hdim_t'(MIN_DIM);
        else if (ve > hcmp_t'(MAX_HEIGHT))
            return hdim_t'(MAX_HEIGHT);
        else
            return hdim_t'(ve);
    endfunction

endpackage

// ===== rtl/mf3_ram.sv =====
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mf3_line_buf.sv =====
module mf3_line_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mf3_pkg::pixel_t     in_pixel,
    input  mf3_pkg::col_t       in_addr,
    input  mf3_pkg::win_ctrl_t  in_ctrl,
    output logic                win_valid,
    output mf3_pkg::pix_win_t   win,
    output mf3_pkg::win_ctrl_t  win_ctrl
);

    logic                s1_valid_reg;
    mf3_pkg::pixel_t     s1_pixel_reg;
    mf3_pkg::col_t       s1_addr_reg;
    mf3_pkg::win_ctrl_t  s1_ctrl_reg;

    logic                fwd_hit_reg;
    mf3_pkg::pixel_t     fwd_up_reg;
    mf3_pkg::pixel_t     fwd_lo_reg;

    mf3_pkg::pix_win_t   window_reg;
    mf3_pkg::pix_win_t   window_next;
    logic                win_valid_reg;
    mf3_pkg::win_ctrl_t  win_ctrl_reg;

    mf3_pkg::pixel_t     ram_up;
    mf3_pkg::pixel_t     ram_lo;
    mf3_pkg::pixel_t     up_eff;
    mf3_pkg::pixel_t     lo_eff;
    logic                wr_en;

    assign wr_en  = en && s1_valid_reg;
    assign up_eff = fwd_hit_reg ? fwd_up_reg : ram_up;
    assign lo_eff = fwd_hit_reg ? fwd_lo_reg : ram_lo;

    // row r-2: takes over what row r-1 held at this column
    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_ram_upper (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (lo_eff),
        .rd_en   (in_valid),
        .rd_addr (in_addr),
        .rd_data (ram_up)
    );

    // row r-1
    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_ram_lower (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_valid),
        .rd_addr (in_addr),
        .rd_data (ram_lo)
    );

    always_comb
    begin
        window_next = window_reg;
        if (wr_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_next[k*3]   = window_reg[k*3+1];
                window_next[k*3+1] = window_reg[k*3+2];
            end
            window_next[2] = up_eff;
            window_next[5] = lo_eff;
            window_next[8] = s1_pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            win_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            if (en)
            begin
                s1_valid_reg  <= in_valid;
                win_valid_reg <= s1_valid_reg && s1_ctrl_reg.emit;
            end
            // the RAM misses a write landing in the same cycle as the read
            if (in_valid)
            begin
                fwd_hit_reg <= wr_en && (in_addr == s1_addr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_pixel_reg <= in_pixel;
            s1_addr_reg  <= in_addr;
            s1_ctrl_reg  <= in_ctrl;
            fwd_up_reg   <= lo_eff;
            fwd_lo_reg   <= s1_pixel_reg;
        end
        if (en)
        begin
            win_ctrl_reg <= s1_ctrl_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = window_reg;
    assign win_ctrl  = win_ctrl_reg;

`ifndef ASSERT_OFF
    a_fwd_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && wr_en && (in_addr == s1_addr_reg)) |=> fwd_hit_reg)
        else $error("same-address read and write not forwarded");
`endif

endmodule

// ===== rtl/mf3_median.sv =====
module mf3_median (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mf3_pkg::pix_win_t   in_win,
    input  mf3_pkg::win_ctrl_t  in_ctrl,
    output logic                out_valid,
    output mf3_pkg::pixel_t     out_pixel,
    output mf3_pkg::win_ctrl_t  out_ctrl
);

    // compare-exchange: upper half is the larger value
    function automatic logic [2*mf3_pkg::PIX_W-1:0] sort2(mf3_pkg::pixel_t a,
                                                          mf3_pkg::pixel_t b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

    logic                sa_valid_reg;
    mf3_pkg::pix_win_t   sa_win_reg;
    mf3_pkg::pixel_t     sa_center_reg;
    mf3_pkg::win_ctrl_t  sa_ctrl_reg;

    logic                sb_valid_reg;
    mf3_pkg::pix_win_t   sb_win_reg;
    mf3_pkg::pixel_t     sb_center_reg;
    mf3_pkg::win_ctrl_t  sb_ctrl_reg;

    logic                out_valid_reg;
    mf3_pkg::pixel_t     out_pixel_reg;
    mf3_pkg::win_ctrl_t  out_ctrl_reg;

    mf3_pkg::pix_win_t   pa;
    mf3_pkg::pix_win_t   pb;
    mf3_pkg::pix_win_t   pc;

    // nineteen-exchange median network, cut into three register stages
    always_comb
    begin
        pa = in_win;
        {pa[2], pa[1]} = sort2(pa[1], pa[2]);
        {pa[5], pa[4]} = sort2(pa[4], pa[5]);
        {pa[8], pa[7]} = sort2(pa[7], pa[8]);
        {pa[1], pa[0]} = sort2(pa[0], pa[1]);
        {pa[4], pa[3]} = sort2(pa[3], pa[4]);
        {pa[7], pa[6]} = sort2(pa[6], pa[7]);
    end

    always_comb
    begin
        pb = sa_win_reg;
        {pb[2], pb[1]} = sort2(pb[1], pb[2]);
        {pb[5], pb[4]} = sort2(pb[4], pb[5]);
        {pb[8], pb[7]} = sort2(pb[7], pb[8]);
        {pb[3], pb[0]} = sort2(pb[0], pb[3]);
        {pb[8], pb[5]} = sort2(pb[5], pb[8]);
        {pb[7], pb[4]} = sort2(pb[4], pb[7]);
        {pb[6], pb[3]} = sort2(pb[3], pb[6]);
        {pb[4], pb[1]} = sort2(pb[1], pb[4]);
        {pb[5], pb[2]} = sort2(pb[2], pb[5]);
    end

    always_comb
    begin
        pc = sb_win_reg;
        {pc[7], pc[4]} = sort2(pc[4], pc[7]);
        {pc[2], pc[4]} = sort2(pc[4], pc[2]);
        {pc[4], pc[6]} = sort2(pc[6], pc[4]);
        {pc[2], pc[4]} = sort2(pc[4], pc[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg  <= 1'b0;
            sb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_valid_reg  <= in_valid;
            sb_valid_reg  <= sa_valid_reg;
            out_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_win_reg    <= pa;
            sa_center_reg <= in_win[4];
            sa_ctrl_reg   <= in_ctrl;
            sb_win_reg    <= pb;
            sb_center_reg <= sa_center_reg;
            sb_ctrl_reg   <= sa_ctrl_reg;
            out_pixel_reg <= sb_ctrl_reg.inner ? pc[4] : sb_center_reg;
            out_ctrl_reg  <= sb_ctrl_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_ctrl  = out_ctrl_reg;

endmodule

// ===== rtl/median_filter_3x3.sv =====
// 3x3 median filter on an 8-bit gray raster stream. One pixel is taken per
// clock, sustained; a result passes the line buffer registers and then the
// median stages, and output stalls hold the whole pipeline. The rate is set
// by the two line-store RAMs, each read and written once per pixel at the
// current column; a write meeting a read of the same column is forwarded. The
// filtered centre lies one row and one column behind the input; the outer
// ring of the image is never emitted and the ring just inside it is passed
// through unfiltered. Line stores need no clearing after reset. Image size
// is written through the configuration channel (index 0 width, index 1 height,
// clamped to 5..maximum); the user must do so only while idle, which the
// block does not enforce; frame_start on a pixel restarts the position counters.
module median_filter_3x3 (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel_in
    input  logic [0:0]  s_tuser,    // [0] frame_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] pixel_out, [18:8] out_row, [29:19] out_col

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    mf3_pkg::wdim_t      w_eff_reg;
    mf3_pkg::hdim_t      h_eff_reg;
    mf3_pkg::col_t       col_reg;
    mf3_pkg::col_t       col_next;
    mf3_pkg::row_t       row_reg;
    mf3_pkg::row_t       row_next;

    mf3_pkg::col_t       col_cur;
    mf3_pkg::row_t       row_cur;
    mf3_pkg::wdim_t      col_ext;
    mf3_pkg::hdim_t      row_ext;
    mf3_pkg::win_ctrl_t  in_ctrl;

    logic                en;
    logic                accept;

    logic                win_valid;
    mf3_pkg::pix_win_t   win;
    mf3_pkg::win_ctrl_t  win_ctrl;
    mf3_pkg::pixel_t     out_pixel;
    mf3_pkg::win_ctrl_t  out_ctrl;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= mf3_pkg::clamp_width(mf3_pkg::cfg_data_t'(640));
            h_eff_reg <= mf3_pkg::clamp_height(mf3_pkg::cfg_data_t'(480));
        end
        else if (cfg_valid)
        begin
            unique case (mf3_pkg::cfg_reg_t'(cfg_index))
                mf3_pkg::REG_IMAGE_WIDTH:  w_eff_reg <= mf3_pkg::clamp_width(cfg_data);
                mf3_pkg::REG_IMAGE_HEIGHT: h_eff_reg <= mf3_pkg::clamp_height(cfg_data);
            endcase
        end
    end

    // position of this pixel and the counters for the next one
    always_comb
    begin
        col_cur = s_tuser[0] ? '0 : col_reg;
        row_cur = s_tuser[0] ? '0 : row_reg;
        col_ext = {1'b0, col_cur};
        row_ext = {1'b0, row_cur};

        in_ctrl.emit  = (row_cur >= mf3_pkg::row_t'(2)) && (col_cur >= mf3_pkg::col_t'(2))
                        && (row_ext < h_eff_reg) && (col_ext < w_eff_reg);
        in_ctrl.inner = (row_cur >= mf3_pkg::row_t'(3)) && (col_cur >= mf3_pkg::col_t'(3))
                        && (row_ext + mf3_pkg::hdim_t'(2) <= h_eff_reg)
                        && (col_ext + mf3_pkg::wdim_t'(2) <= w_eff_reg);
        in_ctrl.row   = mf3_pkg::coord_t'(row_cur - mf3_pkg::row_t'(1));
        in_ctrl.col   = mf3_pkg::coord_t'(col_cur - mf3_pkg::col_t'(1));

        if (col_ext + mf3_pkg::wdim_t'(1) >= w_eff_reg)
        begin
            col_next = '0;
            row_next = (row_ext + mf3_pkg::hdim_t'(1) >= h_eff_reg) ? '0
                       : row_cur + mf3_pkg::row_t'(1);
        end
        else
        begin
            col_next = col_cur + mf3_pkg::col_t'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    mf3_line_buf u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .in_pixel  (s_tdata[7:0]),
        .in_addr   (col_cur),
        .in_ctrl   (in_ctrl),
        .win_valid (win_valid),
        .win       (win),
        .win_ctrl  (win_ctrl)
    );

    mf3_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (win_valid),
        .in_win    (win),
        .in_ctrl   (win_ctrl),
        .out_valid (m_tvalid),
        .out_pixel (out_pixel),
        .out_ctrl  (out_ctrl)
    );

    assign m_tdata = {{(mf3_pkg::M_TDATA_W - mf3_pkg::PIX_W - 2*mf3_pkg::OUT_W){1'b0}},
                      out_ctrl.col, out_ctrl.row, out_pixel};

`ifndef ASSERT_OFF
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser[0]) |=> (col_reg == mf3_pkg::col_t'(1)) && (row_reg == '0))
        else $error("counters not restarted by frame_start");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser[0] && ({1'b0, col_reg} + mf3_pkg::wdim_t'(1) < w_eff_reg))
        |=> (col_reg == mf3_pkg::col_t'($past(col_reg) + mf3_pkg::col_t'(1))))
        else $error("column counter did not advance by one");

    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s_tvalid) |=> $stable(col_reg) && $stable(row_reg))
        else $error("counters moved while the output was stalled");
`endif

endmodule

// ===== tb/median_filter_3x3_tb.sv =====
module median_filter_3x3_tb;
    import mf3_pkg::*;

    typedef struct {
        pixel_t value;
        coord_t row;
        coord_t col;
    } centre_t;

    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_NARROW,
        PIX_PATTERN
    } pix_mode_t;

    // Mirrors the filter: line stores, sliding window, position counters.
    class median_scoreboard;
        pixel_t      upper_line [MAX_WIDTH];
        pixel_t      lower_line [MAX_WIDTH];
        pixel_t      win [9];
        int unsigned col_pos;
        int unsigned row_pos;
        cfg_data_t   width_reg;
        cfg_data_t   height_reg;
        centre_t     pending_centres [$];
        int          mismatches;

        function new();
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = 12'd640;
            height_reg = 12'd480;
            mismatches = 0;
        endfunction

        static function int unsigned eff_size(cfg_data_t v, int unsigned hi);
            if (v < MIN_DIM)
                return MIN_DIM;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // value whose count of smaller samples is at most four and of
        // smaller-or-equal samples more than four
        function pixel_t median9();
            int lt;
            int le;
            for (int i = 0; i < 9; i++)
            begin
                lt = 0;
                le = 0;
                for (int j = 0; j < 9; j++)
                begin
                    if (win[j] < win[i])
                        lt++;
                    if (win[j] <= win[i])
                        le++;
                end
                if (lt <= 4 && le > 4)
                    return win[i];
            end
            return win[4];
        endfunction

        function void set_reg(cfg_reg_t idx, cfg_data_t v);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = v;
                REG_IMAGE_HEIGHT: height_reg = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_centres.size();
        endfunction

        function void note_pixel(pixel_t px, bit fs);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            pixel_t      up;
            pixel_t      lo;
            bit          inner;
            centre_t     e;
            w  = eff_size(width_reg, MAX_WIDTH);
            h  = eff_size(height_reg, MAX_HEIGHT);
            up = '0;
            lo = '0;
            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            r = row_pos;
            c = col_pos;
            if (c < MAX_WIDTH)
            begin
                up = upper_line[c];
                lo = lower_line[c];
                upper_line[c] = lo;
                lower_line[c] = px;
            end
            for (int k = 0; k < 3; k++)
            begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = up;
            win[5] = lo;
            win[8] = px;
            if (r >= 2 && c >= 2 && r < h && c < w)
            begin
                // ring just inside the border passes through unfiltered
                inner   = (r - 1 >= 2) && (r + 2 <= h) && (c - 1 >= 2) && (c + 2 <= w);
                e.value = inner ? median9() : win[4];
                e.row   = coord_t'(r - 1);
                e.col   = coord_t'(c - 1);
                pending_centres.push_back(e);
            end
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_centre(logic [M_TDATA_W-1:0] word);
            centre_t e;
            if (pending_centres.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing pending", word));
                return;
            end
            e = pending_centres.pop_front();
            if (word[PIX_W-1:0] !== e.value)
                report_mismatch($sformatf("centre (%0d,%0d): pixel_out %h, expected %h",
                                          e.row, e.col, word[PIX_W-1:0], e.value));
            if (word[PIX_W+OUT_W-1:PIX_W] !== e.row)
                report_mismatch($sformatf("centre (%0d,%0d): out_row %0d",
                                          e.row, e.col, word[PIX_W+OUT_W-1:PIX_W]));
            if (word[PIX_W+2*OUT_W-1:PIX_W+OUT_W] !== e.col)
                report_mismatch($sformatf("centre (%0d,%0d): out_col %0d",
                                          e.row, e.col, word[PIX_W+2*OUT_W-1:PIX_W+OUT_W]));
            if (word[M_TDATA_W-1:PIX_W+2*OUT_W] !== '0)
                report_mismatch($sformatf("centre (%0d,%0d): padding bits set in %h",
                                          e.row, e.col, word));
        endtask
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [11:0]       cfg_data  = '0;

    median_scoreboard  sb;
    bit                tx_idle_en = 1'b1;
    bit                rx_idle_en = 1'b1;
    bit                hold_req   = 1'b0;
    int unsigned       pixels_sent = 0;

    median_filter_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic pixel_t next_pixel(pix_mode_t mode, int idx);
        case (mode)
            PIX_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 8'h00;
                    1:       return 8'hff;
                    2:       return 8'h01;
                    default: return 8'hfe;
                endcase
            // few distinct values, so ties are common
            PIX_NARROW:  return pixel_t'(8'd100 + $urandom_range(0, 3));
            PIX_PATTERN:
                case (idx % 4)
                    0:       return 8'hff;
                    1:       return 8'h00;
                    2:       return pixel_t'(idx * 9);
                    default: return 8'h80;
                endcase
            default:     return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // valid stays high; the caller lowers it once all requests are done
    task automatic cfg_write(cfg_reg_t idx, cfg_data_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, v);
    endtask

    task automatic write_size(cfg_data_t w, cfg_data_t h);
        if ($urandom_range(0, 1))
        begin
            cfg_write(REG_IMAGE_WIDTH, w);
            cfg_write(REG_IMAGE_HEIGHT, h);
        end
        else
        begin
            cfg_write(REG_IMAGE_HEIGHT, h);
            cfg_write(REG_IMAGE_WIDTH, w);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixels(int count, bit first_fs, pix_mode_t mode);
        pixel_t px;
        bit     fs;
        for (int i = 0; i < count; i++)
        begin
            if (tx_idle_en && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            px = next_pixel(mode, i);
            fs = first_fs && (i == 0);
            s_tvalid <= 1'b1;
            s_tdata  <= px;
            s_tuser  <= fs;
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            sb.note_pixel(px, fs);
            pixels_sent++;
        end
    endtask

    // pixels that emit nothing may still be in flight, hence the tail
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin : rx_side
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_centre(m_tdata);
    end

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned rand_start;
        bit          fs_next;
        cfg_data_t   wr;
        cfg_data_t   hr;

        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, patterned values; only the centre gets filtered
        write_size(12'd5, 12'd5);
        send_pixels(25, 1'b1, PIX_PATTERN);
        drain();

        // long output hold-off early in a frame, then both sizes shrunk below the
        // counters: the next pixel emits nothing and the frame wraps
        write_size(12'd20, 12'd12);
        hold_req = 1'b1;
        send_pixels(175, 1'b1, PIX_UNIFORM);
        drain();
        write_size(12'd8, 12'd6);
        send_pixels(97, 1'b0, PIX_UNIFORM);
        drain();

        rand_start = pixels_sent;
        while (pixels_sent - rand_start < 450)
        begin
            case ($urandom_range(0, 7))
                0:       wr = cfg_data_t'($urandom_range(0, 4));
                1:       wr = 12'd5;
                default: wr = cfg_data_t'($urandom_range(6, 24));
            endcase
            case ($urandom_range(0, 7))
                0:       hr = cfg_data_t'($urandom_range(0, 4));
                1:       hr = 12'd5;
                default: hr = cfg_data_t'($urandom_range(6, 16));
            endcase
            write_size(wr, hr);
            w = median_scoreboard::eff_size(wr, MAX_WIDTH);
            h = median_scoreboard::eff_size(hr, MAX_HEIGHT);
            fs_next = 1'b1;
            repeat ($urandom_range(1, 3))
            begin
                n = w * h;
                // abandoned frame: the next one must restart with frame_start
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(1, n - 1);
                send_pixels(n, fs_next || $urandom_range(0, 1),
                            pix_mode_t'($urandom_range(0, 2)));
                fs_next = (n != w * h);
            end
            drain();
        end

        // height clamped from above: top of a tall, narrow frame
        write_size(12'd3, 12'd4095);
        send_pixels(5 * 12, 1'b1, PIX_UNIFORM);
        drain();
        // width clamped from above: start of a wide row, then abandoned
        write_size(12'd4095, 12'd0);
        send_pixels(64, 1'b1, PIX_UNIFORM);
        drain();

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_size(12'd12, 12'd9);
        send_pixels(12 * 9 * 2, 1'b1, PIX_UNIFORM);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** median_filter_3x3: PASSED **");
        else
            $display("** median_filter_3x3: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #16_000_000;
        $display("** median_filter_3x3: FAILED **");
        $finish;
    end

endmodule
